/* sv/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, sigma functions and sequencer states
// shared by the SHA-256 message hash block.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rot_sum_a(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t rot_sum_e(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t sched_mix_a(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sched_mix_b(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

/* sv/sha256_message_hash_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hash
// Byte-serial SHA-256: packs bytes into 64-byte blocks, pads the message,
// runs one compression round per cycle and returns the eight digest words.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  byte      byte_valid / byte_stall      data_byte[7:0], final_byte
//  digest    digest_valid / digest_stall  digest_word[31:0], word_index[2:0],
//                                         last_word
//
// A message byte is taken whenever byte_stall is low. Each full block then runs
// the shared round unit, and ST_FOLD adds the result into the hash state.
// After the final byte the pad (0x80, zeros, 64-bit length) is shifted in
// one byte per cycle in ST_PAD, up to 72 bytes, with one or two compressions.
// The eight digest words then leave one per cycle while digest_stall is low.
// byte_stall is high whenever the sequencer is not waiting for a byte.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module sha256_message_hash_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha256_pkg::state_t state_reg, state_next;

    sha256_pkg::word_t  h_reg   [8];
    sha256_pkg::word_t  h_next  [8];
    sha256_pkg::word_t  v_reg   [8];
    sha256_pkg::word_t  v_next  [8];
    sha256_pkg::word_t  blk_reg [16];
    sha256_pkg::word_t  blk_next[16];

    logic [63:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        spill_reg, spill_next;
    logic        done_reg, done_next;

    logic [7:0]        shift_byte;
    logic              shift_en;
    logic [63:0]       len_bits;
    logic [7:0]        len_byte;
    sha256_pkg::word_t t1, t2, w_new;

    assign len_bits = {count_reg[60:0], 3'b000};
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // Round unit
    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::rot_sum_e(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::ROUND_K[round_reg] + blk_reg[0];
        t2 = sha256_pkg::rot_sum_a(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = sha256_pkg::sched_mix_b(blk_reg[14]) + blk_reg[9]
              + sha256_pkg::sched_mix_a(blk_reg[1]) + blk_reg[0];
    end

    always_comb
    begin
        state_next   = state_reg;
        h_next       = h_reg;
        v_next       = v_reg;
        blk_next     = blk_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        pad_next     = pad_reg;
        first_next   = first_reg;
        spill_next   = spill_reg;
        done_next    = done_reg;
        shift_en     = 1'b0;
        shift_byte   = 8'h00;

        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (byte_valid)
                begin
                    shift_en   = 1'b1;
                    shift_byte = data_byte;
                    count_next = count_reg + 64'd1;
                    fill_next  = fill_reg + 6'd1;
                    pad_next   = final_byte;
                    first_next = final_byte;
                    if (&fill_reg)
                    begin
                        v_next     = h_reg;
                        round_next = '0;
                        state_next = sha256_pkg::ST_ROUND;
                    end
                    else if (final_byte)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                shift_en   = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                    shift_byte = sha256_pkg::PAD_BYTE;
                else if (!spill_reg && (&fill_reg[5:3]))
                    shift_byte = len_byte;
                else
                    shift_byte = 8'h00;
                // pad byte landing in the last eight slots pushes the length out
                if (first_reg && (&fill_reg[5:3]))
                    spill_next = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (&fill_reg)
                begin
                    spill_next = 1'b0;
                    done_next  = !first_reg && !spill_reg;
                    v_next     = h_reg;
                    round_next = '0;
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                    blk_next[i] = blk_reg[i + 1];
                blk_next[15] = w_new;
                round_next   = round_reg + 6'd1;
                if (&round_reg)
                    state_next = sha256_pkg::ST_FOLD;
            end
            sha256_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] + v_reg[i];
                out_idx_next = '0;
                if (done_reg)
                    state_next = sha256_pkg::ST_OUT;
                else if (pad_reg)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_OUT:
            begin
                if (!digest_stall)
                begin
                    // rotate so the next word sits at the head
                    for (int i = 0; i < 7; i++)
                        h_next[i] = h_reg[i + 1];
                    h_next[7]    = h_reg[0];
                    out_idx_next = out_idx_reg + 3'd1;
                    if (&out_idx_reg)
                    begin
                        h_next     = sha256_pkg::H_INIT;
                        count_next = '0;
                        fill_next  = '0;
                        pad_next   = 1'b0;
                        first_next = 1'b0;
                        spill_next = 1'b0;
                        done_next  = 1'b0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase

        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                blk_next[i] = {blk_reg[i][23:0], blk_reg[i + 1][31:24]};
            blk_next[15] = {blk_reg[15][23:0], shift_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha256_pkg::ST_IDLE;
            h_reg       <= sha256_pkg::H_INIT;
            count_reg   <= '0;
            fill_reg    <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            pad_reg     <= 1'b0;
            first_reg   <= 1'b0;
            spill_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            h_reg       <= h_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            pad_reg     <= pad_next;
            first_reg   <= first_next;
            spill_reg   <= spill_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        blk_reg <= blk_next;
    end

    assign byte_stall   = (state_reg != sha256_pkg::ST_IDLE);
    assign digest_valid = (state_reg == sha256_pkg::ST_OUT);
    assign digest_word  = h_reg[0];
    assign word_index   = out_idx_reg;
    assign last_word    = &out_idx_reg;

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && last_word) |=> !byte_stall)
        else $error("block not ready after last digest word");

    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sha256_pkg::ST_ROUND) &&
         ($past(state_reg) != sha256_pkg::ST_ROUND)) |-> (round_reg == 6'd0))
        else $error("compression started with nonzero round counter");

    a_idle_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_IDLE) |-> (!pad_reg && !done_reg && !spill_reg))
        else $error("padding flags left set while waiting for a byte");

endmodule
`default_nettype wire
